// File: src/teaching_word_machine_core_defines.svh
// Assertion macros used by the checker module of the word machine core.
`ifndef TEACHING_WORD_MACHINE_CORE_DEFINES_SVH
`define TEACHING_WORD_MACHINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("twm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("twm assertion failed");

`endif

// File: src/twm_pkg.sv
`default_nettype none
package twm_pkg;
	localparam int MEM_WORDS   = 100;
	localparam int BLOCK_WORDS = 10;
	localparam int MEM_AW      = $clog2(MEM_WORDS);
	localparam int CNT_W       = $clog2(MEM_WORDS + 1);
	localparam int BLK_W       = $clog2(BLOCK_WORDS + 1);
	localparam int WORD_W      = 32;
	localparam int OPC_W       = 3;
	localparam int STAT_W      = 3;
	localparam int CNT_OUT_W   = 7;
	localparam int DIG_AW      = 7;
	localparam int TDATA_W     = ((WORD_W + CNT_OUT_W + 7) / 8) * 8;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [WORD_W-1:0] SPACES = 32'h2020_2020;

	localparam logic [OPC_W-1:0] OPC_JOB  = 3'd0;
	localparam logic [OPC_W-1:0] OPC_LOAD = 3'd1;
	localparam logic [OPC_W-1:0] OPC_RUN  = 3'd2;
	localparam logic [OPC_W-1:0] OPC_EXEC = 3'd3;
	localparam logic [OPC_W-1:0] OPC_DATA = 3'd4;

	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_T    = 8'h54;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		CMD_JOB,
		CMD_LOAD,
		CMD_RUN,
		CMD_EXEC,
		CMD_DATA,
		CMD_BAD
	} cmd_t;

	typedef struct packed {
		cmd_t  cmd;
		word_t word;
	} item_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 3'd0,
		STAT_PRINT = 3'd1,
		STAT_HALT  = 3'd2,
		STAT_WAIT  = 3'd3,
		STAT_ERR   = 3'd4
	} status_t;

	typedef struct packed {
		logic              addr_ok;
		logic              blk_ok;
		logic [DIG_AW-1:0] addr;
		logic [DIG_AW-1:0] base;
	} addr_dec_t;

	function automatic addr_dec_t decode_addr(input word_t ir);
		logic [7:0] t_c;
		logic [7:0] u_c;
		logic       t_ok;
		logic       u_ok;
		addr_dec_t  d;
		t_c = ir[15:8];
		u_c = ir[7:0];
		t_ok = (t_c >= CH_ZERO) && (t_c <= CH_NINE);
		u_ok = (u_c >= CH_ZERO) && (u_c <= CH_NINE);
		d.base = DIG_AW'({t_c[3:0], 3'b000}) + DIG_AW'({t_c[3:0], 1'b0});
		d.addr = d.base + DIG_AW'(u_c[3:0]);
		d.addr_ok = t_ok && u_ok && (d.addr < DIG_AW'(MEM_WORDS));
		d.blk_ok = t_ok && ((8'(d.base) + 8'(BLOCK_WORDS)) <= 8'(MEM_WORDS));
		return d;
	endfunction
endpackage
`default_nettype wire

// File: src/twm_front.sv
`default_nettype none
module twm_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [twm_pkg::WORD_W-1:0] s_tdata,
	input  wire logic [twm_pkg::OPC_W-1:0]  s_tuser,
	output logic                            push_valid,
	input  wire logic                       push_ready,
	output twm_pkg::item_t                  push_item
);
	logic           vld_s1;
	twm_pkg::item_t item_s1;

	function automatic twm_pkg::cmd_t classify(input logic [twm_pkg::OPC_W-1:0] opc);
		twm_pkg::cmd_t c;
		unique case (opc)
			twm_pkg::OPC_JOB:  c = twm_pkg::CMD_JOB;
			twm_pkg::OPC_LOAD: c = twm_pkg::CMD_LOAD;
			twm_pkg::OPC_RUN:  c = twm_pkg::CMD_RUN;
			twm_pkg::OPC_EXEC: c = twm_pkg::CMD_EXEC;
			twm_pkg::OPC_DATA: c = twm_pkg::CMD_DATA;
			default:           c = twm_pkg::CMD_BAD;
		endcase
		return c;
	endfunction

	assign s_tready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd  <= classify(s_tuser);
			item_s1.word <= s_tdata;
		end
	end
endmodule
`default_nettype wire

// File: src/twm_queue.sv
`default_nettype none
module twm_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire twm_pkg::item_t push_item,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output twm_pkg::item_t      pop_item
);
	twm_pkg::item_t                   slot_q [twm_pkg::QDEPTH];
	logic [twm_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [twm_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [twm_pkg::QCNT_W-1:0]       cnt_q;
	logic                             do_push;
	logic                             do_pop;

	assign push_ready = cnt_q != twm_pkg::QCNT_W'(twm_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [twm_pkg::QPTR_W-1:0] wrap_inc(input logic [twm_pkg::QPTR_W-1:0] p);
		return (p == twm_pkg::QPTR_W'(twm_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

// File: src/twm_back.sv
`default_nettype none
module twm_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	output logic                             q_ready,
	input  wire twm_pkg::item_t              q_item,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [twm_pkg::TDATA_W-1:0]      m_tdata,
	output logic [twm_pkg::STAT_W-1:0]       m_tuser,
	output logic                             m_tlast
);
	typedef enum logic [2:0] {S_IDLE, S_FETCH, S_MEMOP, S_PD_RD, S_PD_EMIT} state_t;
	typedef enum logic [1:0] {M_IDLE, M_RUN, M_WAIT, M_HALT} mode_t;

	localparam int CW = twm_pkg::CNT_W;
	localparam int BW = twm_pkg::BLK_W;
	localparam int AW = twm_pkg::MEM_AW;

	state_t                   state_q;
	mode_t                    mode_q;
	twm_pkg::word_t           gr_q;
	logic                     tog_q;
	logic [CW-1:0]            ic_q;
	logic [CW-1:0]            lp_q;
	logic [CW-1:0]            dp_q;
	logic [BW-1:0]            dr_q;
	logic [CW-1:0]            pd_base_q;
	logic [BW-1:0]            pd_idx_q;
	logic                     is_cr_q;
	logic [twm_pkg::MEM_WORDS-1:0] valid_q;
	twm_pkg::word_t           mem_q [twm_pkg::MEM_WORDS];
	twm_pkg::word_t           rd_data_q;
	logic                     rd_vld_q;

	logic                     out_vld_q;
	twm_pkg::status_t         out_stat_q;
	twm_pkg::word_t           out_word_q;
	logic                     out_last_q;
	logic [CW-1:0]            out_cnt_q;

	logic                     can_load;
	logic                     pop;
	logic                     act;
	twm_pkg::word_t           ir;
	logic [7:0]               op0;
	logic [7:0]               op1;
	twm_pkg::addr_dec_t       dec;
	logic                     is_gd, is_pd, is_h, is_lr, is_sr, is_cr, is_bt;
	logic                     data_ok;
	logic                     ic_ok;
	logic                     lp_ok;
	logic                     pd_last;
	logic [CW-1:0]            pd_addr;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	twm_pkg::word_t           wr_data;

	assign can_load = !out_vld_q || m_tready;
	assign q_ready  = (state_q == S_IDLE) && can_load;
	assign pop      = q_ready && q_valid;
	assign act      = (state_q == S_FETCH) && can_load;

	assign ir  = rd_vld_q ? rd_data_q : twm_pkg::SPACES;
	assign op0 = ir[31:24];
	assign op1 = ir[23:16];
	assign dec = twm_pkg::decode_addr(ir);

	assign is_gd = (op0 == twm_pkg::CH_G) && (op1 == twm_pkg::CH_D);
	assign is_pd = (op0 == twm_pkg::CH_P) && (op1 == twm_pkg::CH_D);
	assign is_h  = (op0 == twm_pkg::CH_H);
	assign is_lr = (op0 == twm_pkg::CH_L) && (op1 == twm_pkg::CH_R);
	assign is_sr = (op0 == twm_pkg::CH_S) && (op1 == twm_pkg::CH_R);
	assign is_cr = (op0 == twm_pkg::CH_C) && (op1 == twm_pkg::CH_R);
	assign is_bt = (op0 == twm_pkg::CH_B) && (op1 == twm_pkg::CH_T);

	assign ic_ok   = ic_q < CW'(twm_pkg::MEM_WORDS);
	assign lp_ok   = lp_q < CW'(twm_pkg::MEM_WORDS);
	assign data_ok = (mode_q == M_WAIT) && (dr_q != '0) && (dp_q < CW'(twm_pkg::MEM_WORDS));
	assign pd_addr = pd_base_q + CW'(pd_idx_q);
	assign pd_last = pd_idx_q == BW'(twm_pkg::BLOCK_WORDS - 1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ic_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = lp_q[AW-1:0];
		wr_data = q_item.word;
		if (pop && (q_item.cmd == twm_pkg::CMD_EXEC) && (mode_q == M_RUN) && ic_ok) begin
			rd_en = 1'b1;
		end
		if (act && (is_lr || is_cr) && dec.addr_ok) begin
			rd_en   = 1'b1;
			rd_addr = dec.addr[AW-1:0];
		end
		if (state_q == S_PD_RD) begin
			rd_en   = 1'b1;
			rd_addr = pd_addr[AW-1:0];
		end
		if (pop && (q_item.cmd == twm_pkg::CMD_LOAD) && lp_ok) begin
			wr_en = 1'b1;
		end
		if (pop && (q_item.cmd == twm_pkg::CMD_DATA) && data_ok) begin
			wr_en   = 1'b1;
			wr_addr = dp_q[AW-1:0];
		end
		if (act && is_sr && dec.addr_ok) begin
			wr_en   = 1'b1;
			wr_addr = dec.addr[AW-1:0];
			wr_data = gr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= M_IDLE;
			gr_q       <= twm_pkg::SPACES;
			tog_q      <= 1'b0;
			ic_q       <= '0;
			lp_q       <= '0;
			dp_q       <= '0;
			dr_q       <= '0;
			pd_base_q  <= '0;
			pd_idx_q   <= '0;
			is_cr_q    <= 1'b0;
			valid_q    <= '0;
			rd_vld_q   <= 1'b0;
			out_vld_q  <= 1'b0;
			out_stat_q <= twm_pkg::STAT_DONE;
			out_word_q <= '0;
			out_last_q <= 1'b0;
			out_cnt_q  <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						out_vld_q  <= 1'b1;
						out_word_q <= '0;
						out_last_q <= 1'b1;
						out_cnt_q  <= ic_q;
						out_stat_q <= twm_pkg::STAT_DONE;
						unique case (q_item.cmd)
							twm_pkg::CMD_JOB: begin
								valid_q   <= '0;
								gr_q      <= twm_pkg::SPACES;
								tog_q     <= 1'b0;
								ic_q      <= '0;
								lp_q      <= '0;
								mode_q    <= M_IDLE;
								dp_q      <= '0;
								dr_q      <= '0;
								out_cnt_q <= '0;
							end
							twm_pkg::CMD_LOAD: begin
								if (lp_ok) begin
									lp_q <= lp_q + 1'b1;
								end else begin
									out_stat_q <= twm_pkg::STAT_ERR;
								end
							end
							twm_pkg::CMD_RUN: begin
								ic_q      <= '0;
								mode_q    <= M_RUN;
								dr_q      <= '0;
								out_cnt_q <= '0;
							end
							twm_pkg::CMD_DATA: begin
								if (data_ok) begin
									dp_q <= dp_q + 1'b1;
									dr_q <= dr_q - BW'(1);
									if (dr_q == BW'(1)) begin
										mode_q <= M_RUN;
									end else begin
										out_stat_q <= twm_pkg::STAT_WAIT;
									end
								end else begin
									out_stat_q <= twm_pkg::STAT_ERR;
								end
							end
							twm_pkg::CMD_EXEC: begin
								unique case (mode_q)
									M_IDLE: out_stat_q <= twm_pkg::STAT_ERR;
									M_WAIT: out_stat_q <= twm_pkg::STAT_WAIT;
									M_HALT: out_stat_q <= twm_pkg::STAT_HALT;
									M_RUN: begin
										if (ic_ok) begin
											out_vld_q <= 1'b0;
											ic_q      <= ic_q + 1'b1;
											state_q   <= S_FETCH;
										end else begin
											mode_q     <= M_IDLE;
											out_stat_q <= twm_pkg::STAT_ERR;
										end
									end
									default: out_stat_q <= twm_pkg::STAT_ERR;
								endcase
							end
							default: out_stat_q <= twm_pkg::STAT_ERR;
						endcase
					end
				end
				S_FETCH: begin
					if (can_load) begin
						out_vld_q  <= 1'b1;
						out_word_q <= '0;
						out_last_q <= 1'b1;
						out_cnt_q  <= ic_q;
						out_stat_q <= twm_pkg::STAT_DONE;
						state_q    <= S_IDLE;
						priority if (is_gd) begin
							if (dec.blk_ok) begin
								dp_q       <= CW'(dec.base);
								dr_q       <= BW'(twm_pkg::BLOCK_WORDS);
								mode_q     <= M_WAIT;
								out_stat_q <= twm_pkg::STAT_WAIT;
							end else begin
								mode_q     <= M_IDLE;
								out_stat_q <= twm_pkg::STAT_ERR;
							end
						end else if (is_pd) begin
							if (dec.blk_ok) begin
								pd_base_q <= CW'(dec.base);
								pd_idx_q  <= '0;
								out_vld_q <= 1'b0;
								state_q   <= S_PD_RD;
							end else begin
								mode_q     <= M_IDLE;
								out_stat_q <= twm_pkg::STAT_ERR;
							end
						end else if (is_h) begin
							mode_q     <= M_HALT;
							out_stat_q <= twm_pkg::STAT_HALT;
						end else if (is_lr || is_cr) begin
							if (dec.addr_ok) begin
								is_cr_q   <= is_cr;
								out_vld_q <= 1'b0;
								state_q   <= S_MEMOP;
							end else begin
								mode_q     <= M_IDLE;
								out_stat_q <= twm_pkg::STAT_ERR;
							end
						end else if (is_sr) begin
							if (!dec.addr_ok) begin
								mode_q     <= M_IDLE;
								out_stat_q <= twm_pkg::STAT_ERR;
							end
						end else if (is_bt && tog_q) begin
							if (dec.addr_ok) begin
								ic_q      <= CW'(dec.addr);
								out_cnt_q <= CW'(dec.addr);
							end else begin
								mode_q     <= M_IDLE;
								out_stat_q <= twm_pkg::STAT_ERR;
							end
						end
					end
				end
				S_MEMOP: begin
					if (can_load) begin
						if (is_cr_q) begin
							tog_q <= ir == gr_q;
						end else begin
							gr_q <= ir;
						end
						out_vld_q  <= 1'b1;
						out_word_q <= '0;
						out_last_q <= 1'b1;
						out_cnt_q  <= ic_q;
						out_stat_q <= twm_pkg::STAT_DONE;
						state_q    <= S_IDLE;
					end
				end
				S_PD_RD: begin
					state_q <= S_PD_EMIT;
				end
				S_PD_EMIT: begin
					if (can_load) begin
						out_vld_q  <= 1'b1;
						out_word_q <= ir;
						out_last_q <= pd_last;
						out_cnt_q  <= ic_q;
						out_stat_q <= twm_pkg::STAT_PRINT;
						if (pd_last) begin
							state_q <= S_IDLE;
						end else begin
							pd_idx_q <= pd_idx_q + 1'b1;
							state_q  <= S_PD_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = twm_pkg::TDATA_W'({twm_pkg::CNT_OUT_W'(out_cnt_q), out_word_q});
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;
endmodule
`default_nettype wire

// File: src/teaching_word_machine_core.sv
`default_nettype none
// Word machine core with 100 words of four ASCII characters, driven by host events on the
// input stream: job start, program load, run start, execute step and GD data words. Each
// event yields one result transaction, except an executed PD, which yields ten print
// transactions, the last one marked by m_tlast. Events pass through an input register and
// a two-entry queue to the executing back end, so the input keeps taking transactions while
// a result waits on the output register. The back end handles one event at a time through
// the single-port main memory: a job start, load, run start, data word or non-running step
// is answered from the idle state, an instruction step is a fetch read and then an execute,
// LR and CR add an operand read, and PD reads and emits each block word. Job start clears
// memory at once through per-word valid bits, so no clearing pass follows reset.
module teaching_word_machine_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [twm_pkg::WORD_W-1:0]  s_tdata,   // word[31:0]
	input  wire logic [twm_pkg::OPC_W-1:0]   s_tuser,   // opcode[2:0]
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [twm_pkg::TDATA_W-1:0]      m_tdata,   // print_word[31:0], counter[38:32]
	output logic [twm_pkg::STAT_W-1:0]       m_tuser,   // status[2:0]
	output logic                             m_tlast
);
	logic           push_valid;
	logic           push_ready;
	twm_pkg::item_t push_item;
	logic           pop_valid;
	logic           pop_ready;
	twm_pkg::item_t pop_item;

	twm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	twm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	twm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_ready  (pop_ready),
		.q_item   (pop_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);
endmodule
`default_nettype wire

// File: src/twm_checker.sv
`default_nettype none
`include "teaching_word_machine_core_defines.svh"
module twm_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [twm_pkg::TDATA_W-1:0] m_tdata,
	input wire logic [twm_pkg::STAT_W-1:0] m_tuser,
	input wire logic                       m_tlast
);
	logic not_print;

	assign not_print = m_tuser != twm_pkg::STAT_PRINT;

	`TWM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`TWM_ASSERT_SAME(a_single_last, clk, arst_n, m_tvalid && not_print, m_tlast)
	`TWM_ASSERT_SAME(a_word_zero, clk, arst_n, m_tvalid && not_print, m_tdata[31:0] == '0)
	`TWM_ASSERT_SAME(a_counter_range, clk, arst_n, m_tvalid, m_tdata[38:32] <= 7'(twm_pkg::MEM_WORDS))
endmodule

bind teaching_word_machine_core twm_checker u_twm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// File: verif/teaching_word_machine_core_checker.sv
`timescale 1ns / 1ps
module teaching_word_machine_core_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [twm_pkg::WORD_W-1:0]  s_tdata,   // word[31:0]
	input  wire logic [twm_pkg::OPC_W-1:0]   s_tuser,   // opcode[2:0]
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [twm_pkg::TDATA_W-1:0] m_tdata,   // print_word[31:0], counter[38:32]
	input  wire logic [twm_pkg::STAT_W-1:0]  m_tuser,   // status[2:0]
	input  wire logic                        m_tlast,
	output int                               mismatch_count,
	output int                               replies_pending,
	output int                               replies_checked,
	output int                               printed_words
);
	import twm_pkg::*;

	typedef enum logic [1:0] {
		RM_IDLE,
		RM_RUN,
		RM_WAIT,
		RM_HALT
	} run_mode_t;

	typedef struct packed {
		status_t                status;
		word_t                  print_word;
		logic                   last;
		logic [CNT_OUT_W-1:0]   counter;
	} reply_t;

	word_t                core_mem [MEM_WORDS];
	word_t                acc;
	logic                 flag;
	logic [CNT_OUT_W-1:0] pc;
	logic [CNT_OUT_W-1:0] load_at;
	logic [CNT_OUT_W-1:0] fill_at;
	logic [BLK_W-1:0]     fill_left;
	run_mode_t            mode;
	reply_t               replies_due [$];

	function automatic bit ascii_digit(input logic [7:0] ch, output int val);
		val = int'(ch) - int'(CH_ZERO);
		return (ch >= CH_ZERO) && (ch <= CH_NINE);
	endfunction

	task automatic clear_machine();
		int i;
		for (i = 0; i < MEM_WORDS; i++)
			core_mem[i] = SPACES;
		acc = SPACES;
		flag = 1'b0;
		pc = '0;
		load_at = '0;
		fill_at = '0;
		fill_left = '0;
		mode = RM_IDLE;
	endtask

	task automatic post_reply(input status_t st, input word_t pw, input logic lst);
		reply_t r;
		r.status = st;
		r.print_word = pw;
		r.last = lst;
		r.counter = pc;
		replies_due.push_back(r);
	endtask

	task automatic run_instruction();
		word_t      ir;
		logic [7:0] op0;
		logic [7:0] op1;
		int         tens;
		int         units;
		int         target;
		int         i;
		bit         tens_ok;
		bit         units_ok;
		bit         addr_ok;
		bit         block_ok;
		bit         bad;
		if (mode == RM_IDLE) begin
			post_reply(STAT_ERR, '0, 1'b1);
		end else if (mode == RM_WAIT) begin
			post_reply(STAT_WAIT, '0, 1'b1);
		end else if (mode == RM_HALT) begin
			post_reply(STAT_HALT, '0, 1'b1);
		end else if (pc >= MEM_WORDS) begin
			mode = RM_IDLE;
			post_reply(STAT_ERR, '0, 1'b1);
		end else begin
			ir = core_mem[pc];
			pc = pc + 1'b1;
			op0 = ir[31:24];
			op1 = ir[23:16];
			tens_ok = ascii_digit(ir[15:8], tens);
			units_ok = ascii_digit(ir[7:0], units);
			target = tens * 10 + units;
			addr_ok = tens_ok && units_ok && (target < MEM_WORDS);
			block_ok = tens_ok && (tens * 10 + BLOCK_WORDS <= MEM_WORDS);
			bad = 1'b0;
			if (op0 == CH_G && op1 == CH_D) begin
				if (block_ok) begin
					fill_at = CNT_OUT_W'(tens * 10);
					fill_left = BLK_W'(BLOCK_WORDS);
					mode = RM_WAIT;
					post_reply(STAT_WAIT, '0, 1'b1);
				end else begin
					bad = 1'b1;
				end
			end else if (op0 == CH_P && op1 == CH_D) begin
				if (block_ok) begin
					for (i = 0; i < BLOCK_WORDS; i++)
						post_reply(STAT_PRINT, core_mem[tens * 10 + i], i == BLOCK_WORDS - 1);
				end else begin
					bad = 1'b1;
				end
			end else if (op0 == CH_H) begin
				mode = RM_HALT;
				post_reply(STAT_HALT, '0, 1'b1);
			end else begin
				if (op0 == CH_L && op1 == CH_R) begin
					if (addr_ok) acc = core_mem[target];
					else bad = 1'b1;
				end else if (op0 == CH_S && op1 == CH_R) begin
					if (addr_ok) core_mem[target] = acc;
					else bad = 1'b1;
				end else if (op0 == CH_C && op1 == CH_R) begin
					if (addr_ok) flag = (core_mem[target] == acc);
					else bad = 1'b1;
				end else if (op0 == CH_B && op1 == CH_T && flag) begin
					if (addr_ok) pc = CNT_OUT_W'(target);
					else bad = 1'b1;
				end
				if (!bad) post_reply(STAT_DONE, '0, 1'b1);
			end
			if (bad) begin
				mode = RM_IDLE;
				post_reply(STAT_ERR, '0, 1'b1);
			end
		end
	endtask

	task automatic emulate_event(input logic [OPC_W-1:0] opc, input word_t w);
		case (opc)
			OPC_JOB: begin
				clear_machine();
				post_reply(STAT_DONE, '0, 1'b1);
			end
			OPC_LOAD: begin
				if (load_at < MEM_WORDS) begin
					core_mem[load_at] = w;
					load_at = load_at + 1'b1;
					post_reply(STAT_DONE, '0, 1'b1);
				end else begin
					post_reply(STAT_ERR, '0, 1'b1);
				end
			end
			OPC_RUN: begin
				pc = '0;
				mode = RM_RUN;
				fill_left = '0;
				post_reply(STAT_DONE, '0, 1'b1);
			end
			OPC_EXEC: run_instruction();
			OPC_DATA: begin
				if (mode == RM_WAIT && fill_left != 0 && fill_at < MEM_WORDS) begin
					core_mem[fill_at] = w;
					fill_at = fill_at + 1'b1;
					fill_left = fill_left - 1'b1;
					if (fill_left == 0) begin
						mode = RM_RUN;
						post_reply(STAT_DONE, '0, 1'b1);
					end else begin
						post_reply(STAT_WAIT, '0, 1'b1);
					end
				end else begin
					post_reply(STAT_ERR, '0, 1'b1);
				end
			end
			default: post_reply(STAT_ERR, '0, 1'b1);
		endcase
	endtask

	// Results are compared before the accepted event is predicted, so a result can
	// never be matched against an expectation pushed in the same cycle.
	always @(posedge clk or negedge arst_n) begin : watch
		reply_t                 due;
		logic [CNT_OUT_W-1:0]   got_count;
		if (!arst_n) begin
			clear_machine();
			replies_due.delete();
			mismatch_count = 0;
			replies_checked = 0;
			printed_words = 0;
			replies_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_count = m_tdata[WORD_W +: CNT_OUT_W];
				if (replies_due.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result transaction, got status %0d word %h last %b counter %0d",
						$time, m_tuser, m_tdata[WORD_W-1:0], m_tlast, got_count);
				end else begin
					due = replies_due.pop_front();
					replies_checked++;
					if (m_tuser == STAT_PRINT) printed_words++;
					if (m_tuser !== due.status || m_tdata[WORD_W-1:0] !== due.print_word ||
							m_tlast !== due.last || got_count !== due.counter) begin
						mismatch_count++;
						$display("%0t: expected status %0d word %h last %b counter %0d, got status %0d word %h last %b counter %0d",
							$time, due.status, due.print_word, due.last, due.counter,
							m_tuser, m_tdata[WORD_W-1:0], m_tlast, got_count);
					end
				end
			end
			if (s_tvalid && s_tready) emulate_event(s_tuser, s_tdata);
			replies_pending <= replies_due.size();
		end
	end
endmodule

// File: verif/teaching_word_machine_core_tb.sv
`timescale 1ns / 1ps
module teaching_word_machine_core_tb;
	import twm_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 80;
	localparam int RANDOM_EVENTS = 160;

	localparam logic [OPC_W-1:0] OPC_SPARE_LO = 3'd5;
	localparam logic [OPC_W-1:0] OPC_SPARE_HI = 3'd7;

	typedef enum int {
		INS_GD,
		INS_PD,
		INS_LR,
		INS_SR,
		INS_CR,
		INS_BT,
		INS_JUNK,
		INS_H
	} instr_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [WORD_W-1:0]    s_tdata = '0;
	logic [OPC_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [STAT_W-1:0]    m_tuser;
	logic                 m_tlast;

	int mismatch_count;
	int replies_pending;
	int replies_checked;
	int printed_words;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int events_sent = 0;

	teaching_word_machine_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	teaching_word_machine_core_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatch_count  (mismatch_count),
		.replies_pending (replies_pending),
		.replies_checked (replies_checked),
		.printed_words   (printed_words)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[teaching_word_machine_core] ERROR");
			$finish;
		end
	end

	// A long hold keeps the output stalled while the sender keeps offering events.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			m_tready <= 1'b0;
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic logic [7:0] digit_char(input int n);
		return CH_ZERO + 8'(n);
	endfunction

	function automatic logic [7:0] loose_char();
		if ($urandom_range(0, 5) == 0) return 8'($urandom());
		return digit_char($urandom_range(0, 9));
	endfunction

	function automatic word_t addr_instr(input logic [7:0] a, input logic [7:0] b,
			input int target);
		return {a, b, digit_char(target / 10), digit_char(target % 10)};
	endfunction

	function automatic word_t data_word();
		case ($urandom_range(0, 3))
			0: return SPACES;
			1: return {loose_char(), loose_char(), loose_char(), loose_char()};
			default: return $urandom();
		endcase
	endfunction

	task automatic set_pace(input int phase);
		case (phase)
			0: begin idle_pct = 0; stall_pct <= 0; end
			1: begin idle_pct = 69; stall_pct <= 0; end
			2: begin idle_pct = 0; stall_pct <= 69; end
			default: begin idle_pct = 21; stall_pct <= 21; end
		endcase
	endtask

	task automatic send_event(input logic [OPC_W-1:0] opc, input word_t w);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= opc;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		events_sent++;
	endtask

	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (replies_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The program reads the last block, prints it, sets the toggle on a space word,
	// branches to the block and runs off the end of memory.
	task automatic run_directed();
		int i;
		send_event(OPC_SPARE_HI, 32'hFFFF_FFFF);
		send_event(OPC_EXEC, '0);
		send_event(OPC_DATA, $urandom());
		send_event(OPC_JOB, '0);
		send_event(OPC_LOAD, {CH_G, CH_D, CH_NINE, CH_ZERO});
		send_event(OPC_LOAD, {CH_P, CH_D, CH_NINE, CH_ZERO});
		send_event(OPC_LOAD, addr_instr(CH_C, CH_R, MEM_WORDS - 1));
		send_event(OPC_LOAD, addr_instr(CH_B, CH_T, MEM_WORDS - 2));
		send_event(OPC_RUN, 32'hFFFF_FFFF);
		send_event(OPC_EXEC, '0);
		send_event(OPC_EXEC, '0);
		for (i = 0; i < BLOCK_WORDS; i++) begin
			if (i == 0) send_event(OPC_DATA, '0);
			else if (i == BLOCK_WORDS - 1) send_event(OPC_DATA, SPACES);
			else if (i == 1 || i == BLOCK_WORDS - 2) send_event(OPC_DATA, 32'hFFFF_FFFF);
			else send_event(OPC_DATA, $urandom());
		end
		repeat (6) send_event(OPC_EXEC, $urandom());
	endtask

	// The loads step through all four pacing mixes.
	task automatic overfill_memory();
		int i;
		send_event(OPC_JOB, $urandom());
		for (i = 0; i < MEM_WORDS + 1; i++) begin
			if (i % 26 == 0) set_pace(i / 26);
			send_event(OPC_LOAD, (i % 3 == 0) ? data_word() : word_t'($urandom()));
		end
		send_event(OPC_RUN, $urandom());
		send_event(OPC_EXEC, $urandom());
	endtask

	task automatic run_job();
		instr_kind_t plan [$];
		instr_kind_t pick;
		word_t       w;
		int          n;
		int          i;
		int          j;
		int          words;
		n = $urandom_range(2, 8);
		if ($urandom_range(0, 3) == 0)
			send_event(OPC_SPARE_LO + OPC_W'($urandom_range(0, 2)), $urandom());
		if ($urandom_range(0, 7) != 0) send_event(OPC_JOB, $urandom());
		for (i = 0; i < n; i++) begin
			if (i == n - 1 && $urandom_range(0, 1) == 0) pick = INS_H;
			else pick = instr_kind_t'($urandom_range(0, 6));
			case (pick)
				INS_GD: w = {CH_G, CH_D, digit_char($urandom_range(2, 9)), loose_char()};
				INS_PD: w = {CH_P, CH_D, digit_char($urandom_range(0, 9)), loose_char()};
				INS_LR: w = addr_instr(CH_L, CH_R, $urandom_range(0, MEM_WORDS - 1));
				INS_SR: w = addr_instr(CH_S, CH_R, $urandom_range(20, MEM_WORDS - 1));
				INS_CR: w = addr_instr(CH_C, CH_R, $urandom_range(0, MEM_WORDS - 1));
				INS_BT: begin
					j = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MEM_WORDS - 1) : i + 1;
					w = addr_instr(CH_B, CH_T, j);
				end
				INS_H: w = {CH_H, 8'($urandom()), 16'($urandom())};
				default: w = $urandom();
			endcase
			if (pick != INS_JUNK && pick != INS_H && $urandom_range(0, 11) == 0) begin
				if ($urandom_range(0, 1) == 0) w[15:8] = 8'($urandom());
				else w[7:0] = 8'($urandom());
			end
			plan.push_back(pick);
			send_event(OPC_LOAD, w);
		end
		send_event(OPC_RUN, $urandom());
		for (i = 0; i < n; i++) begin
			send_event(OPC_EXEC, $urandom());
			if (plan[i] == INS_GD) begin
				if ($urandom_range(0, 7) == 0) words = $urandom_range(0, BLOCK_WORDS - 1);
				else words = BLOCK_WORDS;
				for (j = 0; j < words; j++) send_event(OPC_DATA, data_word());
			end
			if ($urandom_range(0, 24) == 0)
				send_event(OPC_W'($urandom_range(0, 7)), $urandom());
		end
		for (i = $urandom_range(0, 2); i > 0; i--) send_event(OPC_EXEC, $urandom());
	endtask

	initial begin : stimulus
		int job_no;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		set_pace(0);
		run_directed();
		wait_for_replies();
		hold_requests <= hold_requests + 1;
		overfill_memory();
		wait_for_replies();
		job_no = 0;
		while (events_sent < RANDOM_EVENTS) begin
			set_pace(job_no % 4);
			if (job_no % 7 == 3) wait_for_replies();
			run_job();
			job_no++;
		end
		wait_for_replies();
		$display("Coverage: %0d host events in %0d random jobs plus a directed program and a memory overfill.",
			events_sent, job_no);
		$display("Checked %0d result transactions, %0d printed words, under four pacing mixes.",
			replies_checked, printed_words);
		if (mismatch_count == 0) begin
			$display("[teaching_word_machine_core] OK");
		end else begin
			$display("[teaching_word_machine_core] ERROR");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+src
src/twm_pkg.sv
src/twm_front.sv
src/twm_queue.sv
src/twm_back.sv
src/teaching_word_machine_core.sv
src/twm_checker.sv
verif/teaching_word_machine_core_checker.sv
verif/teaching_word_machine_core_tb.sv
